### src/gnf_pkg.sv
// Shared types and constants for the gradient noise fBm block.
`timescale 1ns / 1ps
package gnf_pkg;

  localparam int GRID_SIZE_DEF    = 256;
  localparam int OCTAVE_COUNT_DEF = 4;
  localparam int OCT_IDX_W        = 3;

  localparam logic [15:0] GAIN_RESET = 16'd32768;
  localparam logic [16:0] SQRT2_Q16  = 17'd92682;
  localparam logic [19:0] HEIGHT_MAX = 20'hFFFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_TL, ST_RD_TR, ST_RD_BL, ST_RD_BR, ST_DOT_BR,
    ST_BLEND_X, ST_BLEND_Y, ST_SCALE, ST_ACCUM, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_START, OP_RD_TL, OP_RD_TR, OP_RD_BL, OP_RD_BR,
    OP_DOT_BR, OP_BLEND_X, OP_BLEND_Y, OP_SCALE, OP_ACCUM, OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t                 op;
    logic [OCT_IDX_W-1:0]   oct;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

### src/gradient_noise_fbm.sv
// Top level of the 2D gradient noise fBm block.
`timescale 1ns / 1ps
// Gradient noise summed over octaves. A write item (action 0) stores one Q1.14
// gradient pair at (row, col) of a GRID_SIZE x GRID_SIZE table; it gives no
// result. An evaluate item (action 1) gives one height in Q4.16. Each octave
// runs four corner reads through the single table port, the dot product of the
// last corner, the two blend steps, scaling and accumulation; the item is taken
// before the first octave and the output is loaded after the last, once the
// output register is free. The table is not cleared at reset; evaluate only
// where all four corners have been written.
// GRID_SIZE must be a power of two. octave_gain (Q0.16, reset 0.5) is to be
// written on the cfg channel only while the block is idle; the block itself
// does not enforce this. cfg_ready is always high. The output register lets
// write items go on while a height waits to be taken.
module gradient_noise_fbm #(
  parameter int GRID_SIZE    = gnf_pkg::GRID_SIZE_DEF,
  parameter int OCTAVE_COUNT = gnf_pkg::OCTAVE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [7:0]         in_row,
  input  logic [7:0]         in_col,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [19:0]        out_height,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_octave_gain
);

  gnf_pkg::dp_cmd_t cmd;
  gnf_pkg::dp_sts_t sts;

  // the user must change configuration only while idle; the block does not enforce this, and it is always taken
  assign cfg_ready = 1'b1;

  gnf_ctrl #(.OCTAVE_COUNT(OCTAVE_COUNT)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  gnf_dp #(.GRID_SIZE(GRID_SIZE), .OCTAVE_COUNT(OCTAVE_COUNT)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_grad_x       (in_grad_x),
    .in_grad_y       (in_grad_y),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_octave_gain (cfg_octave_gain),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_height      (out_height)
  );

endmodule

### src/gnf_ram.sv
// Single-port RAM with registered read.
`timescale 1ns / 1ps
module gnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/gnf_ctrl.sv
// Sequencer: walks each octave through corner reads, blends, scaling and accumulation.
`timescale 1ns / 1ps
module gnf_ctrl #(
  parameter int OCTAVE_COUNT = gnf_pkg::OCTAVE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_action,
  output logic             in_stall,
  output gnf_pkg::dp_cmd_t cmd,
  input  gnf_pkg::dp_sts_t sts
);

  gnf_pkg::state_t                    state_r, state_nxt;
  logic [gnf_pkg::OCT_IDX_W-1:0]      oct_r, oct_nxt;
  logic                               last_oct;

  assign last_oct = (oct_r == gnf_pkg::OCT_IDX_W'(OCTAVE_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gnf_pkg::ST_IDLE;
      oct_r   <= '0;
    end else begin
      state_r <= state_nxt;
      oct_r   <= oct_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    oct_nxt   = oct_r;
    unique case (state_r)
      gnf_pkg::ST_IDLE: begin
        if (in_valid && in_action) begin
          state_nxt = gnf_pkg::ST_RD_TL;
          oct_nxt   = '0;
        end
      end
      gnf_pkg::ST_RD_TL:   state_nxt = gnf_pkg::ST_RD_TR;
      gnf_pkg::ST_RD_TR:   state_nxt = gnf_pkg::ST_RD_BL;
      gnf_pkg::ST_RD_BL:   state_nxt = gnf_pkg::ST_RD_BR;
      gnf_pkg::ST_RD_BR:   state_nxt = gnf_pkg::ST_DOT_BR;
      gnf_pkg::ST_DOT_BR:  state_nxt = gnf_pkg::ST_BLEND_X;
      gnf_pkg::ST_BLEND_X: state_nxt = gnf_pkg::ST_BLEND_Y;
      gnf_pkg::ST_BLEND_Y: state_nxt = gnf_pkg::ST_SCALE;
      gnf_pkg::ST_SCALE:   state_nxt = gnf_pkg::ST_ACCUM;
      gnf_pkg::ST_ACCUM: begin
        if (last_oct) begin
          state_nxt = gnf_pkg::ST_FIN;
        end else begin
          state_nxt = gnf_pkg::ST_RD_TL;
          oct_nxt   = oct_r + 1'b1;
        end
      end
      gnf_pkg::ST_FIN: begin
        if (!sts.out_busy) begin
          state_nxt = gnf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gnf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.oct  = oct_r;
    cmd.op   = gnf_pkg::OP_NONE;
    in_stall = 1'b1;
    unique case (state_r)
      gnf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = in_action ? gnf_pkg::OP_START : gnf_pkg::OP_WRITE;
        end
      end
      gnf_pkg::ST_RD_TL:   cmd.op = gnf_pkg::OP_RD_TL;
      gnf_pkg::ST_RD_TR:   cmd.op = gnf_pkg::OP_RD_TR;
      gnf_pkg::ST_RD_BL:   cmd.op = gnf_pkg::OP_RD_BL;
      gnf_pkg::ST_RD_BR:   cmd.op = gnf_pkg::OP_RD_BR;
      gnf_pkg::ST_DOT_BR:  cmd.op = gnf_pkg::OP_DOT_BR;
      gnf_pkg::ST_BLEND_X: cmd.op = gnf_pkg::OP_BLEND_X;
      gnf_pkg::ST_BLEND_Y: cmd.op = gnf_pkg::OP_BLEND_Y;
      gnf_pkg::ST_SCALE:   cmd.op = gnf_pkg::OP_SCALE;
      gnf_pkg::ST_ACCUM:   cmd.op = gnf_pkg::OP_ACCUM;
      gnf_pkg::ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.op = gnf_pkg::OP_LOAD_OUT;
        end
      end
      default: cmd.op = gnf_pkg::OP_NONE;
    endcase
  end

endmodule

### src/gnf_dp.sv
// Datapath: gradient table, corner dot products, fade, blends and octave sum.
`timescale 1ns / 1ps
module gnf_dp #(
  parameter int GRID_SIZE    = gnf_pkg::GRID_SIZE_DEF,
  parameter int OCTAVE_COUNT = gnf_pkg::OCTAVE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gnf_pkg::dp_cmd_t   cmd,
  output gnf_pkg::dp_sts_t   sts,
  input  logic [7:0]         in_row,
  input  logic [7:0]         in_col,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_octave_gain,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [19:0]        out_height
);

  localparam int GW = $clog2(GRID_SIZE);
  localparam int AW = 2 * GW;

  function automatic logic signed [34:0] blend(input logic signed [34:0] a,
                                               input logic signed [34:0] b,
                                               input logic [16:0] w);
    logic signed [35:0] diff;
    logic signed [53:0] prod;
    begin
      diff  = 36'(b) - 36'(a);
      prod  = 54'(diff) * 54'($signed({1'b0, w}));
      blend = 35'(a + 35'(prod >>> 16));
    end
  endfunction

  logic [15:0]        gain_r;
  logic [GW-1:0]      row_r, col_r;
  logic [15:0]        w_r;
  logic [19:0]        sum_r;
  logic               out_valid_r;
  logic [19:0]        out_height_r;

  logic [31:0]        t2x_r, t2y_r;
  logic [47:0]        t3x_r, t3y_r;
  logic [19:0]        kx_r, ky_r;
  logic [16:0]        fx_r, fy_r;
  logic signed [34:0] dot_r [4];
  logic signed [34:0] bx0_r, bx1_r, n_r;
  logic [20:0]        val_r;

  // cell geometry of the current octave
  logic [3:0]         sh;
  logic [GW-1:0]      msk, left, right, top, bot;
  logic [15:0]        dx, dy;
  logic signed [17:0] ox_l, ox_r, oy_t, oy_b;

  always_comb begin
    int s;
    s = GW - OCTAVE_COUNT + int'(cmd.oct);
    if (s < 0) begin
      s = 0;
    end
    sh    = 4'(s);
    msk   = ~({GW{1'b1}} << sh);
    left  = col_r & ~msk;
    top   = row_r & ~msk;
    right = left + (GW'(1) << sh);
    bot   = top + (GW'(1) << sh);
    dx    = 16'(32'(col_r & msk) << (5'd16 - 5'(sh)));
    dy    = 16'(32'(row_r & msk) << (5'd16 - 5'(sh)));
    ox_l  = $signed({2'b00, dx});
    ox_r  = $signed({2'b00, dx}) - 18'sd65536;
    oy_t  = -$signed({2'b00, dy});
    oy_b  = 18'sd65536 - $signed({2'b00, dy});
  end

  // table port
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [31:0]     ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {in_grad_y, in_grad_x};
    ram_addr  = {top, left};
    case (cmd.op)
      gnf_pkg::OP_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = {GW'(in_row), GW'(in_col)};
      end
      gnf_pkg::OP_RD_TR: ram_addr = {top, right};
      gnf_pkg::OP_RD_BL: ram_addr = {bot, left};
      gnf_pkg::OP_RD_BR: ram_addr = {bot, right};
      default:           ram_addr = {top, left};
    endcase
  end

  gnf_ram #(.WIDTH(32), .DEPTH(GRID_SIZE * GRID_SIZE)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // dot of the corner read in the previous cycle
  logic signed [15:0] gx, gy;
  logic signed [17:0] ox, oy;
  logic signed [34:0] dot;
  logic [1:0]         dsel;

  always_comb begin
    gx = ram_rdata[15:0];
    gy = ram_rdata[31:16];
    case (cmd.op)
      gnf_pkg::OP_RD_TR: begin dsel = 2'd0; ox = ox_l; oy = oy_t; end
      gnf_pkg::OP_RD_BL: begin dsel = 2'd1; ox = ox_r; oy = oy_t; end
      gnf_pkg::OP_RD_BR: begin dsel = 2'd2; ox = ox_l; oy = oy_b; end
      default:           begin dsel = 2'd3; ox = ox_r; oy = oy_b; end
    endcase
    dot = 35'(34'(gx) * 34'(ox)) + 35'(34'(gy) * 34'(oy));
  end

  // fade polynomial terms, sqrt(2) scaling, weighted octave term and next octave weight
  logic [39:0] inx, iny;
  logic [51:0] fpx, fpy;
  logic [21:0] term_sum;
  logic [36:0] term;
  logic [50:0] scl;
  logic [31:0] wn;

  always_comb begin
    inx = 40'(t2x_r) * 40'd6 + (40'd10 << 32) - ((40'(dx) * 40'd15) << 16);
    iny = 40'(t2y_r) * 40'd6 + (40'd10 << 32) - ((40'(dy) * 40'd15) << 16);
    fpx = 52'(t3x_r[47:16]) * 52'(kx_r);
    fpy = 52'(t3y_r[47:16]) * 52'(ky_r);
    scl = 51'(n_r[33:0]) * 51'(gnf_pkg::SQRT2_Q16);
    term = 37'(val_r) * 37'(w_r);
    term_sum = 22'(sum_r) + 22'(term[36:16]);
    wn = 32'(w_r) * 32'(gain_r);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      gnf_pkg::OP_START: begin
        row_r <= GW'(in_row);
        col_r <= GW'(in_col);
        w_r   <= gain_r;
        sum_r <= '0;
      end
      gnf_pkg::OP_RD_TL: begin
        t2x_r <= 32'(dx) * 32'(dx);
        t2y_r <= 32'(dy) * 32'(dy);
      end
      gnf_pkg::OP_RD_TR: begin
        t3x_r <= 48'(t2x_r) * 48'(dx);
        t3y_r <= 48'(t2y_r) * 48'(dy);
        kx_r  <= inx[35:16];
        ky_r  <= iny[35:16];
      end
      gnf_pkg::OP_RD_BL: begin
        fx_r <= fpx[48:32];
        fy_r <= fpy[48:32];
      end
      gnf_pkg::OP_BLEND_X: begin
        bx0_r <= blend(dot_r[0], dot_r[1], fx_r);
        bx1_r <= blend(dot_r[2], dot_r[3], fx_r);
      end
      gnf_pkg::OP_BLEND_Y: n_r <= blend(bx0_r, bx1_r, fy_r);
      gnf_pkg::OP_SCALE:   val_r <= n_r[34] ? 21'd0 : scl[50:30];
      gnf_pkg::OP_ACCUM: begin
        sum_r <= (term_sum > 22'(gnf_pkg::HEIGHT_MAX)) ? gnf_pkg::HEIGHT_MAX
                                                         : term_sum[19:0];
        w_r   <= wn[31:16];
      end
      default: ;
    endcase
    if (cmd.op == gnf_pkg::OP_RD_TR || cmd.op == gnf_pkg::OP_RD_BL ||
        cmd.op == gnf_pkg::OP_RD_BR || cmd.op == gnf_pkg::OP_DOT_BR) begin
      dot_r[dsel] <= dot;
    end
    if (cmd.op == gnf_pkg::OP_LOAD_OUT) begin
      out_height_r <= sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= gnf_pkg::GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gain_r <= cfg_octave_gain;
      end
      if (cmd.op == gnf_pkg::OP_LOAD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_busy = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_height   = out_height_r;

endmodule

### bench/tb_top.sv
// Self-checking bench for the gradient noise fBm block: queued stimulus, predictor, monitor.
`timescale 1ns / 1ps
module tb_top;

  localparam int GRID    = gnf_pkg::GRID_SIZE_DEF;
  localparam int OCTAVES = gnf_pkg::OCTAVE_COUNT_DEF;
  localparam int DRAIN_CYCLES = 9 * OCTAVES + 2 + 8; // block latency plus margin
  localparam longint CYCLE_LIMIT = 3000000;
  localparam bit ACT_WRITE = 1'b0;
  localparam bit ACT_EVAL  = 1'b1;

  typedef struct {
    bit                 action;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
  } noise_item_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic [7:0]         in_row;
  logic [7:0]         in_col;
  logic signed [15:0] in_grad_x;
  logic signed [15:0] in_grad_y;
  logic               out_valid;
  logic               out_stall;
  logic [19:0]        out_height;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_octave_gain;

  gradient_noise_fbm u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_grad_x      (in_grad_x),
    .in_grad_y      (in_grad_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_height     (out_height),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_octave_gain(cfg_octave_gain)
  );

  // Predictor state: the mirrored gradient table and the current gain.
  bit [31:0]   grad_tab [GRID*GRID];
  bit [15:0]   gain_mirror;

  noise_item_t pending_items [$];   // filled by the stimulus block, drained by the driver
  logic [19:0] height_expected [$]; // heights awaiting the output side
  int          error_count;
  longint      cycle_count = 0;
  bit          idle_free;           // when set, neither side inserts gaps

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_free || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  // Quintic fade 6t^5 - 15t^4 + 10t^3 on a Q0.16 offset; >>> floors toward minus infinity.
  function automatic longint fade_q16(longint t);
    longint t3, k;
    t3 = t * t * t;
    k  = (6 * t * t - 15 * t * 65536 + 10 * (64'sd1 <<< 32)) >>> 16;
    return ((t3 >>> 16) * k) >>> 32;
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint w);
    return (b * w + a * (65536 - w)) >>> 16;
  endfunction

  function automatic longint corner_dot(int r, int c, longint ox, longint oy);
    bit [31:0] e;
    e = grad_tab[(r % GRID) * GRID + (c % GRID)];
    return longint'($signed(e[15:0])) * ox + longint'($signed(e[31:16])) * oy;
  endfunction

  // Clamped, sqrt(2)-scaled noise of one octave with period p, in Q.16.
  function automatic longint octave_noise(int row, int col, int p);
    int     lft, top, rgt, bot;
    longint dx, dy, s, t, u, v, fx, fy, n;
    lft = (col / p) * p;
    top = (row / p) * p;
    rgt = (lft + p) % GRID;
    bot = (top + p) % GRID;
    dx  = (longint'(col - lft) <<< 16) / p;
    dy  = (longint'(row - top) <<< 16) / p;
    s   = corner_dot(top, lft, dx, -dy);
    t   = corner_dot(top, rgt, dx - 65536, -dy);
    u   = corner_dot(bot, lft, dx, 65536 - dy);
    v   = corner_dot(bot, rgt, dx - 65536, 65536 - dy);
    fx  = fade_q16(dx);
    fy  = fade_q16(dy);
    n   = lerp_q16(lerp_q16(s, t, fx), lerp_q16(u, v, fx), fy);
    if (n < 0) n = 0;
    return (n * longint'(gnf_pkg::SQRT2_Q16)) >>> 30;
  endfunction

  // Apply one accepted item to the mirror; evaluates queue their height.
  function automatic void predict_height(noise_item_t it);
    longint sum, w;
    int     p;
    if (it.action == ACT_WRITE) begin
      grad_tab[int'(it.row) * GRID + int'(it.col)] = {it.gy, it.gx};
      return;
    end
    sum = 0;
    w   = gain_mirror;
    for (int o = 0; o < OCTAVES; o++) begin
      p = GRID >> (OCTAVES - o);
      if (p == 0) p = 1;
      if (o > 0) w = (w * gain_mirror) >>> 16;
      sum += (octave_noise(it.row, it.col, p) * w) >>> 16;
      if (sum > longint'(gnf_pkg::HEIGHT_MAX)) sum = gnf_pkg::HEIGHT_MAX;
    end
    height_expected.push_back(sum[19:0]);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Driver: holds a stalled item, otherwise counts down its gap and presents the next.
  int gap_left;
  always @(posedge clk) begin
    bit          holding;
    noise_item_t nxt;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_action <= ACT_WRITE;
      in_row    <= '0;
      in_col    <= '0;
      in_grad_x <= '0;
      in_grad_y <= '0;
      gap_left  <= 0;
    end else begin
      holding = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        nxt.action = in_action;
        nxt.row    = in_row;
        nxt.col    = in_col;
        nxt.gx     = in_grad_x;
        nxt.gy     = in_grad_y;
        predict_height(nxt);
      end
      if (!holding) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          nxt = pending_items.pop_front();
          in_valid  <= 1'b1;
          in_action <= nxt.action;
          in_row    <= nxt.row;
          in_col    <= nxt.col;
          in_grad_x <= nxt.gx;
          in_grad_y <= nxt.gy;
          gap_left  <= pick_gap();
        end
      end
    end
  end

  // Monitor: checks each taken height against the oldest prediction, stalls at random.
  int stall_left;
  always @(posedge clk) begin
    logic [19:0] want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (height_expected.size() == 0) begin
          report_mismatch($sformatf("height %0d with none predicted", out_height));
        end else begin
          want = height_expected.pop_front();
          if (out_height !== want)
            report_mismatch($sformatf("height %0d, predicted %0d", out_height, want));
        end
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= pick_gap();
        out_stall  <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic noise_item_t make_item(bit act, int r, int c, int gx, int gy);
    noise_item_t it;
    it.action = act;
    it.row    = r[7:0];
    it.col    = c[7:0];
    it.gx     = gx[15:0];
    it.gy     = gy[15:0];
    return it;
  endfunction

  function automatic int rand_grad();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 65535) - 32768; // full 16-bit, beyond +-1.0 in Q1.14 too
    if (r == 1) return ($urandom_range(0, 1) != 0) ? 16384 : -16384;
    return $urandom_range(0, 32768) - 16384;
  endfunction

  // Wait until the block has nothing in flight, then let its latency pass.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || height_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Gain may only change while idle; both sides of the handshake are honoured.
  task automatic write_gain(input bit [15:0] g);
    wait_drained();
    cfg_valid       <= 1'b1;
    cfg_octave_gain <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    gain_mirror = g;
  endtask

  task automatic random_items(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        pending_items.push_back(make_item(ACT_EVAL, $urandom_range(0, 255),
                                          $urandom_range(0, 255), rand_grad(), rand_grad()));
      else if (r < 80) // re-load a lattice gradient so later reads see new values
        pending_items.push_back(make_item(ACT_WRITE, $urandom_range(0, 15) * 16,
                                          $urandom_range(0, 15) * 16, rand_grad(), rand_grad()));
      else // random-position write: read back only when it lands on the lattice
        pending_items.push_back(make_item(ACT_WRITE, $urandom_range(0, 255),
                                          $urandom_range(0, 255), rand_grad(), rand_grad()));
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_octave_gain = '0;
    error_count     = 0;
    idle_free       = 1'b0;
    gain_mirror     = gnf_pkg::GAIN_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Every octave's corners sit on multiples of 16, so loading that lattice
    // covers every read an evaluate can make. Extremes are mixed in.
    for (int r = 0; r < GRID; r += 16)
      for (int c = 0; c < GRID; c += 16)
        pending_items.push_back(make_item(ACT_WRITE, r, c, rand_grad(), rand_grad()));
    pending_items.push_back(make_item(ACT_WRITE, 0, 0, 16384, 16384));
    pending_items.push_back(make_item(ACT_WRITE, 0, 16, -16384, 16384));
    pending_items.push_back(make_item(ACT_WRITE, 16, 0, 32767, -32768));
    pending_items.push_back(make_item(ACT_WRITE, 16, 16, -32768, 32767));
    pending_items.push_back(make_item(ACT_WRITE, 255, 255, 0, 0));

    // Directed evaluates at reset gain: grid corners, wrap edge, cell centres.
    pending_items.push_back(make_item(ACT_EVAL, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_EVAL, 255, 255, 0, 0));
    pending_items.push_back(make_item(ACT_EVAL, 8, 8, 0, 0));
    pending_items.push_back(make_item(ACT_EVAL, 240, 15, 0, 0));
    pending_items.push_back(make_item(ACT_EVAL, 127, 128, -1, -1));
    pending_items.push_back(make_item(ACT_EVAL, 1, 254, 0, 0));

    write_gain(16'hFFFF); // strongest weighting, sum most likely to saturate
    pending_items.push_back(make_item(ACT_EVAL, 8, 8, 0, 0));
    pending_items.push_back(make_item(ACT_EVAL, 4, 12, 0, 0));
    pending_items.push_back(make_item(ACT_EVAL, 255, 0, 0, 0));
    random_items(300);

    write_gain(16'h0000); // every term weighted to zero
    pending_items.push_back(make_item(ACT_EVAL, 8, 8, 0, 0));
    random_items(150);

    write_gain(16'h0001);
    random_items(150);

    // Random gains; one phase runs with no gaps on either side.
    for (int ph = 0; ph < 5; ph++) begin
      write_gain(16'($urandom_range(0, 65535)));
      idle_free = (ph == 2);
      random_items(280);
    end
    idle_free = 1'b0;

    write_gain(gnf_pkg::GAIN_RESET);
    random_items(100);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### gradient_noise_fbm.f
src/gnf_pkg.sv
src/gnf_ram.sv
src/gnf_ctrl.sv
src/gnf_dp.sv
src/gradient_noise_fbm.sv
bench/tb_top.sv
